/* design/tinyjambu_aead_core_defines.svh */
// ----------------------------------------------------------------------------
// tinyjambu_aead_core_defines
// assertion macros of the tinyjambu round engine (tj_back); empty under synthesis
// ----------------------------------------------------------------------------
`ifndef TINYJAMBU_AEAD_CORE_DEFINES_SVH
`define TINYJAMBU_AEAD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TJ_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tinyjambu core assertion failed");
// next-cycle implication
`define TJ_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tinyjambu core assertion failed");
`else
`define TJ_ASSERT_IMP(lbl, pre, post)
`define TJ_ASSERT_NXT(lbl, pre, post)
`endif

`endif

/* design/tj_aead_pkg.sv */
// ----------------------------------------------------------------------------
// tj_aead_pkg
// shared types, operation codes and constants of the tinyjambu core
// ----------------------------------------------------------------------------
`default_nettype none

package tj_aead_pkg;

  // operation codes after classification
  typedef logic [2:0] tj_op_t;
  localparam tj_op_t OP_INIT  = 3'd0;
  localparam tj_op_t OP_NONCE = 3'd1;
  localparam tj_op_t OP_AD    = 3'd2;
  localparam tj_op_t OP_MSG   = 3'd3;
  localparam tj_op_t OP_FINAL = 3'd4;
  localparam tj_op_t OP_NONE  = 3'd5;

  // raw action field values
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_NONCE = 3'd1;
  localparam logic [2:0] ACT_AD    = 3'd2;
  localparam logic [2:0] ACT_MSG   = 3'd3;
  localparam logic [2:0] ACT_FINAL = 3'd4;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    tj_op_t      op;
    logic [31:0] data;
    logic [31:0] mask;
    logic        full;
    logic [2:0]  nbytes;
    logic [63:0] exp_tag;
  } tj_cmd_t;

  typedef struct packed {
    logic    valid;
    tj_cmd_t cmd;
  } tj_qhead_t;

endpackage

`default_nettype wire

/* design/tj_front.sv */
// ----------------------------------------------------------------------------
// tj_front
// input side: takes items and turns them into commands for the round engine
// ----------------------------------------------------------------------------
`default_nettype none

module tj_front
  import tj_aead_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_data_in,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic [63:0] in_expected_tag,
  input  wire logic        q_full,
  output logic             q_push,
  output tj_cmd_t          q_cmd
);

  logic [31:0] part_mask;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    case (in_valid_bytes[1:0])
      2'd1:    part_mask = 32'h0000_00FF;
      2'd2:    part_mask = 32'h0000_FFFF;
      2'd3:    part_mask = 32'h00FF_FFFF;
      default: part_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    q_cmd.data    = in_data_in;
    q_cmd.exp_tag = in_expected_tag;
    q_cmd.nbytes  = in_valid_bytes;
    q_cmd.full    = in_valid_bytes[2];
    q_cmd.mask    = in_valid_bytes[2] ? 32'hFFFF_FFFF : part_mask;
    unique case (in_action)
      ACT_INIT:  q_cmd.op = OP_INIT;
      ACT_NONCE: begin
        // nonce words always absorb the whole word
        q_cmd.op   = OP_NONCE;
        q_cmd.full = 1'b1;
        q_cmd.mask = 32'hFFFF_FFFF;
      end
      ACT_AD:    q_cmd.op = OP_AD;
      ACT_MSG:   q_cmd.op = OP_MSG;
      ACT_FINAL: q_cmd.op = OP_FINAL;
      default:   q_cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* design/tj_queue.sv */
// ----------------------------------------------------------------------------
// tj_queue
// short command fifo between the front and the round engine
// ----------------------------------------------------------------------------
`default_nettype none

module tj_queue
  import tj_aead_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire tj_cmd_t push_cmd,
  output logic         full,
  input  wire logic    pop,
  output tj_qhead_t    head
);

  tj_cmd_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* design/tj_back.sv */
// ----------------------------------------------------------------------------
// tj_back
// round engine: 32 nlfsr rounds per cycle, absorb, tag and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "tinyjambu_aead_core_defines.svh"

module tj_back
  import tj_aead_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [127:0] key,
  input  wire logic         decrypt,
  input  wire tj_qhead_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       out_data_out,
  output logic [63:0]       out_tag,
  output logic              out_tag_ok
);

  typedef logic [3:0][31:0] tj_state_t;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  localparam logic [31:0] FRAME_NONCE = 32'h10;
  localparam logic [31:0] FRAME_AD    = 32'h30;
  localparam logic [31:0] FRAME_MSG   = 32'h50;
  localparam logic [31:0] FRAME_FINAL = 32'h70;
  localparam int ROUNDS_SHORT = 640;
  localparam int ROUNDS_LONG  = 1024;
  localparam logic [4:0] LAST_SHORT = 5'(ROUNDS_SHORT / 32 - 1);
  localparam logic [4:0] LAST_LONG  = 5'(ROUNDS_LONG / 32 - 1);

  function automatic tj_state_t tj_round32(tj_state_t s, logic [31:0] kw);
    logic [31:0] t47, t70, t85, t91, fb;
    tj_state_t   r;
    t47 = {s[2][14:0], s[1][31:15]};
    t70 = {s[3][5:0],  s[2][31:6]};
    t85 = {s[3][20:0], s[2][31:21]};
    t91 = {s[3][26:0], s[2][31:27]};
    fb  = s[0] ^ t47 ^ ~(t70 & t85) ^ t91 ^ kw;
    r[0] = s[1];
    r[1] = s[2];
    r[2] = s[3];
    r[3] = fb;
    return r;
  endfunction

  logic [1:0]  state_r, state_nxt;
  tj_state_t   s_r, s_nxt;
  tj_cmd_t     cmd_r, cmd_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [4:0]  last_r, last_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] t0_r, t0_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] dout_r, dout_nxt;
  logic [63:0] tag_r, tag_nxt;
  logic        ok_r, ok_nxt;

  logic [31:0] key_word;
  logic        out_free;
  logic [31:0] msg_out;
  logic [31:0] absorb;
  logic [63:0] tag_calc;

  always_comb begin
    case (step_r[1:0])
      2'd0:    key_word = key[31:0];
      2'd1:    key_word = key[63:32];
      2'd2:    key_word = key[95:64];
      default: key_word = key[127:96];
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign msg_out  = (s_r[2] ^ cmd_r.data) & cmd_r.mask;
  assign absorb   = (cmd_r.op == OP_MSG && decrypt) ? msg_out : (cmd_r.data & cmd_r.mask);
  assign tag_calc = {s_r[2], t0_r};

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    t0_nxt        = t0_r;
    dout_nxt      = dout_r;
    tag_nxt       = tag_r;
    ok_nxt        = ok_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head.cmd;
          step_nxt  = '0;
          phase_nxt = 1'b0;
          state_nxt = ST_RUN;
          last_nxt  = LAST_LONG;
          case (q_head.cmd.op)
            OP_INIT:  s_nxt = '0;
            OP_NONCE: begin
              s_nxt[1] = s_r[1] ^ FRAME_NONCE;
              last_nxt = LAST_SHORT;
            end
            OP_AD: begin
              s_nxt[1] = s_r[1] ^ FRAME_AD;
              last_nxt = LAST_SHORT;
            end
            OP_MSG:   s_nxt[1] = s_r[1] ^ FRAME_MSG;
            OP_FINAL: s_nxt[1] = s_r[1] ^ FRAME_FINAL;
            default:  state_nxt = ST_POST;
          endcase
        end
      end

      ST_RUN: begin
        s_nxt    = tj_round32(s_r, key_word);
        step_nxt = step_r + 1'b1;
        if (step_r == last_r) begin
          state_nxt = ST_POST;
        end
      end

      ST_POST: begin
        if (cmd_r.op == OP_FINAL && !phase_r) begin
          // first tag word taken, second squeeze follows
          t0_nxt    = s_r[2];
          s_nxt[1]  = s_r[1] ^ FRAME_FINAL;
          last_nxt  = LAST_SHORT;
          step_nxt  = '0;
          phase_nxt = 1'b1;
          state_nxt = ST_RUN;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          dout_nxt      = '0;
          tag_nxt       = '0;
          ok_nxt        = 1'b0;
          state_nxt     = ST_IDLE;
          case (cmd_r.op) inside
            OP_NONCE, OP_AD, OP_MSG: begin
              s_nxt[3] = s_r[3] ^ absorb;
              if (!cmd_r.full) begin
                s_nxt[1] = s_r[1] ^ {29'd0, cmd_r.nbytes};
              end
              if (cmd_r.op == OP_MSG) begin
                dout_nxt = msg_out;
              end
            end
            OP_FINAL: begin
              tag_nxt = tag_calc;
              ok_nxt  = (tag_calc == cmd_r.exp_tag);
            end
            default: ;
          endcase
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_r         <= '0;
      step_r      <= '0;
      last_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    t0_r   <= t0_nxt;
    dout_r <= dout_nxt;
    tag_r  <= tag_nxt;
    ok_r   <= ok_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = dout_r;
  assign out_tag      = tag_r;
  assign out_tag_ok   = ok_r;

  `TJ_ASSERT_IMP(a_step_in_range, state_r == ST_RUN, step_r <= last_r)
  `TJ_ASSERT_IMP(a_pop_when_idle, q_pop, state_r == ST_IDLE && q_head.valid)
  `TJ_ASSERT_NXT(a_result_kept, out_valid_r && out_stall, out_valid_r)
  `TJ_ASSERT_NXT(a_final_second_pass,
                 state_r == ST_POST && cmd_r.op == OP_FINAL && !phase_r,
                 state_r == ST_RUN && phase_r && last_r == LAST_SHORT)

endmodule

`default_nettype wire

/* design/tinyjambu_aead_core.sv */
// init and message items run the long permutation, nonce and associated
// data the short one, finalize the long then the short; items wait in the
// queue when they pile up. the 32-round-per-cycle nlfsr unit works on one
// item at a time; the two-entry command queue takes items until it is full
// reset: synchronous active-low rst_n clears the state, key, mode and queue
// ----------------------------------------------------------------------------
// tinyjambu_aead_core
// tinyjambu-128 authenticated cipher core with apb configuration
// ----------------------------------------------------------------------------
`default_nettype none

module tinyjambu_aead_core
  import tj_aead_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_data_in,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic [63:0] in_expected_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_data_out,
  output logic [63:0]      out_tag,
  output logic             out_tag_ok
);

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_DECRYPT  = 2'd2;

  logic [63:0] key_low_r, key_high_r;
  logic        decrypt_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  logic      q_full, q_push, q_pop;
  tj_cmd_t   q_cmd;
  tj_qhead_t q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      decrypt_r  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LOW:  key_low_r  <= pwdata;
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_DECRYPT:  decrypt_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_r;
      REG_KEY_HIGH: prdata = key_high_r;
      REG_DECRYPT:  prdata = {63'd0, decrypt_r};
      default:      prdata = '0;
    endcase
  end

  tj_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_in      (in_data_in),
    .in_valid_bytes  (in_valid_bytes),
    .in_expected_tag (in_expected_tag),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  tj_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  tj_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .key          ({key_high_r, key_low_r}),
    .decrypt      (decrypt_r),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_tag      (out_tag),
    .out_tag_ok   (out_tag_ok)
  );

endmodule

`default_nettype wire

/* tb/tinyjambu_aead_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tinyjambu_aead_core_tb
// self-checking bench: drives init, nonce, associated-data, message and
// finalize items under random idling and back-pressure, predicts every result
// with its own nlfsr model, and switches key and mode between phases
// ----------------------------------------------------------------------------

module tinyjambu_aead_core_tb;
  import tj_aead_pkg::*;

  localparam int          RESET_CYCLES = 11;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          PHASE_ITEMS = 318;
  localparam int          NUM_PHASES = 6;
  localparam int          LONG_HOLD = 400;
  localparam int unsigned LONG_PERM = 1024;
  localparam int unsigned SHORT_PERM = 640;
  localparam logic [31:0] FR_NONCE = 32'h10;
  localparam logic [31:0] FR_AD = 32'h30;
  localparam logic [31:0] FR_MSG = 32'h50;
  localparam logic [31:0] FR_FINAL = 32'h70;
  localparam logic [2:0]  ACT_UNUSED = 3'd5;
  localparam logic [4:0]  REG_KEY_LOW = 5'd0;
  localparam logic [4:0]  REG_KEY_HIGH = 5'd8;
  localparam logic [4:0]  REG_MODE = 5'd16;

  typedef struct packed {
    logic [31:0] data_out;
    logic [63:0] tag;
    logic        tag_ok;
  } cipher_out_t;

  // keyed nlfsr model plus the results still owed by the block
  class aead_tracker;
    logic [3:0][31:0] nl;
    logic [127:0]     key128;
    logic             decrypt;
    cipher_out_t      awaited[$];
    int               errors;

    function new();
      nl = '0;
      key128 = '0;
      decrypt = 1'b0;
      errors = 0;
    endfunction

    function void permute(int unsigned rounds);
      logic [31:0] t47, t70, t85, t91, fb;
      for (int i = 0; i < int'(rounds / 32); i++) begin
        t47 = {nl[2][14:0], nl[1][31:15]};
        t70 = {nl[3][5:0], nl[2][31:6]};
        t85 = {nl[3][20:0], nl[2][31:21]};
        t91 = {nl[3][26:0], nl[2][31:27]};
        fb = nl[0] ^ t47 ^ ~(t70 & t85) ^ t91 ^ key128[(i & 3) * 32 +: 32];
        nl = {fb, nl[3], nl[2], nl[1]};
      end
    endfunction

    function logic [63:0] squeeze_tag();
      logic [31:0] t0;
      nl[1] ^= FR_FINAL;
      permute(LONG_PERM);
      t0 = nl[2];
      nl[1] ^= FR_FINAL;
      permute(SHORT_PERM);
      return {nl[2], t0};
    endfunction

    // tag the next finalize would give, state left untouched
    function logic [63:0] peek_tag();
      logic [3:0][31:0] saved;
      logic [63:0]      t;
      saved = nl;
      t = squeeze_tag();
      nl = saved;
      return t;
    endfunction

    function void note_item(logic [2:0] act, logic [31:0] d, logic [2:0] nb,
                            logic [63:0] et);
      cipher_out_t r;
      logic [31:0] mask;
      logic [31:0] soak;
      r = '0;
      mask = nb[2] ? 32'hFFFF_FFFF : ((32'd1 << (8 * nb)) - 32'd1);
      case (act) inside
        ACT_INIT: begin
          nl = '0;
          permute(LONG_PERM);
        end
        ACT_NONCE: begin
          nl[1] ^= FR_NONCE;
          permute(SHORT_PERM);
          nl[3] ^= d;
        end
        ACT_AD, ACT_MSG: begin
          if (act == ACT_AD) begin
            nl[1] ^= FR_AD;
            permute(SHORT_PERM);
            soak = d & mask;
          end else begin
            nl[1] ^= FR_MSG;
            permute(LONG_PERM);
            r.data_out = (nl[2] ^ d) & mask;
            soak = decrypt ? r.data_out : (d & mask);
          end
          nl[3] ^= soak;
          // partial or empty word folds its byte count into word 1
          if (!nb[2]) nl[1] ^= {29'd0, nb};
        end
        ACT_FINAL: begin
          r.tag = squeeze_tag();
          r.tag_ok = (r.tag == et);
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [31:0] d, logic [63:0] t, logic ok);
      cipher_out_t want;
      if (awaited.size() == 0) begin
        $error("unexpected item: data_out %h tag %h tag_ok %b", d, t, ok);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (d !== want.data_out) begin
        $error("data_out: expected %h, actual %h", want.data_out, d);
        errors++;
      end
      if (t !== want.tag) begin
        $error("tag: expected %h, actual %h", want.tag, t);
        errors++;
      end
      if (ok !== want.tag_ok) begin
        $error("tag_ok: expected %b, actual %b", want.tag_ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [31:0] in_data_in = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic [63:0] in_expected_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_data_out;
  logic [63:0] out_tag;
  logic        out_tag_ok;

  aead_tracker cipher = new();
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          rx_hold_cycles = 0;

  tinyjambu_aead_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_in      (in_data_in),
    .in_valid_bytes  (in_valid_bytes),
    .in_expected_tag (in_expected_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_out    (out_data_out),
    .out_tag         (out_tag),
    .out_tag_ok      (out_tag_ok)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or one long counted hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      cipher.check_result(out_data_out, out_tag, out_tag_ok);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // byte count of a word that is not the last one
  function automatic logic [2:0] body_bytes();
    return ($urandom_range(4, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
  endfunction

  // last word: often full, often partial, sometimes empty or oversized
  function automatic logic [2:0] tail_bytes();
    int r;
    r = $urandom_range(9, 0);
    if (r < 4) return 3'd4;
    if (r < 8) return 3'($urandom_range(3, 1));
    if (r == 8) return 3'd0;
    return 3'($urandom_range(7, 5));
  endfunction

  task automatic push_item(input logic [2:0] act, input logic [31:0] d,
                           input logic [2:0] vb, input logic [63:0] et);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_data_in      <= d;
    in_valid_bytes  <= vb;
    in_expected_tag <= et;
    do @(posedge clk); while (in_stall);
    cipher.note_item(act, d, vb, et);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (cipher.awaited.size() != 0);
  endtask

  task automatic cfg_write(input logic [4:0] addr, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      REG_KEY_LOW:  cipher.key128[63:0] = val;
      REG_KEY_HIGH: cipher.key128[127:64] = val;
      REG_MODE:     cipher.decrypt = val[0];
      default: ;
    endcase
  endtask

  task automatic directed_items();
    push_item(ACT_INIT, '1, 3'd0, '1);
    // nonce words always absorb the full word
    push_item(ACT_NONCE, 32'h0, 3'd0, '0);
    push_item(ACT_NONCE, '1, 3'd7, '1);
    push_item(ACT_NONCE, $urandom, 3'd4, rand64());
    push_item(ACT_AD, '1, 3'd4, rand64());
    push_item(ACT_AD, '1, 3'd1, rand64());
    push_item(ACT_AD, '1, 3'd2, rand64());
    push_item(ACT_AD, 32'h1234_5678, 3'd3, rand64());
    push_item(ACT_AD, $urandom, 3'd0, rand64());
    push_item(ACT_AD, '1, 3'd5, rand64());
    push_item(ACT_MSG, 32'h0, 3'd4, '0);
    push_item(ACT_MSG, '1, 3'd7, '1);
    push_item(ACT_MSG, '1, 3'd1, rand64());
    push_item(ACT_MSG, $urandom, 3'd2, rand64());
    push_item(ACT_MSG, $urandom, 3'd3, rand64());
    push_item(ACT_MSG, $urandom, 3'd0, rand64());
    push_item(ACT_MSG, $urandom, 3'd6, rand64());
    for (int k = 0; k < 3; k++)
      push_item(ACT_UNUSED + 3'(k), $urandom, 3'($urandom_range(7, 0)), rand64());
    push_item(ACT_FINAL, $urandom, 3'd4, '0);
    push_item(ACT_FINAL, $urandom, 3'd4, cipher.peek_tag());
    push_item(ACT_INIT, $urandom, 3'd4, rand64());
    // near miss: one tag bit off
    push_item(ACT_FINAL, $urandom, 3'd4, cipher.peek_tag() ^ {1'b1, 63'd0});
  endtask

  task automatic run_session();
    int          n_nonce, n_ad, n_msg;
    logic [63:0] et;
    if ($urandom_range(9, 0) != 0)
      push_item(ACT_INIT, $urandom, 3'($urandom_range(7, 0)), rand64());
    n_nonce = ($urandom_range(4, 0) == 0) ? $urandom_range(4, 0) : 3;
    for (int i = 0; i < n_nonce; i++)
      push_item(ACT_NONCE, $urandom, 3'($urandom_range(7, 0)), rand64());
    n_ad = $urandom_range(4, 0);
    for (int i = 0; i < n_ad; i++)
      push_item(ACT_AD, $urandom, (i == n_ad - 1) ? tail_bytes() : body_bytes(),
                rand64());
    n_msg = $urandom_range(6, 0);
    for (int i = 0; i < n_msg; i++)
      push_item(ACT_MSG, $urandom, (i == n_msg - 1) ? tail_bytes() : body_bytes(),
                rand64());
    // noise: any action, any byte count
    if ($urandom_range(9, 0) == 0)
      repeat ($urandom_range(3, 1))
        push_item(3'($urandom_range(7, 0)), $urandom, 3'($urandom_range(7, 0)),
                  rand64());
    case ($urandom_range(3, 0)) inside
      0, 1: et = cipher.peek_tag();
      2:    et = cipher.peek_tag() ^ (64'd1 << $urandom_range(63, 0));
      default: et = rand64();
    endcase
    push_item(ACT_FINAL, $urandom, 3'($urandom_range(7, 0)), et);
  endtask

  initial begin
    logic [63:0] kl, kh;
    logic        md;
    int          phase_end;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 19;
    recv_idle_pct = 68;
    directed_items();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 68;
        recv_idle_pct = 19;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      case (p)
        0:       begin kl = '0;       kh = '0;       md = 1'b0; end
        1:       begin kl = '1;       kh = '1;       md = 1'b1; end
        2:       begin kl = rand64(); kh = rand64(); md = 1'b0; end
        3:       begin kl = rand64(); kh = rand64(); md = 1'b1; end
        4:       begin kl = rand64(); kh = '1;       md = 1'b0; end
        default: begin kl = '0;       kh = rand64(); md = 1'b1; end
      endcase
      cfg_write(REG_KEY_LOW, kl);
      cfg_write(REG_KEY_HIGH, kh);
      cfg_write(REG_MODE, {63'd0, md});
      // long receiver hold while items keep coming, so the input backs up
      if (p == 4) rx_hold_cycles = LONG_HOLD;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        run_session();
        if ($urandom_range(31, 0) == 0) drain_results();
      end
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cipher.errors == 0 && cipher.awaited.size() == 0)
      $display("** tinyjambu_aead_core: PASSED **");
    else
      $display("** tinyjambu_aead_core: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** tinyjambu_aead_core: FAILED **");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/tj_aead_pkg.sv
design/tj_front.sv
design/tj_queue.sv
design/tj_back.sv
design/tinyjambu_aead_core.sv
tb/tinyjambu_aead_core_tb.sv
